// ===== design/circular_queue_with_dump_macros.svh =====
// ----------------------------------------------------------------------------
// Circular queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define CQD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the check holds at the next clock edge.
`define CQD_ASSERT_NEXT(label, trig, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (check)) \
        else $error(msg);

`endif

// ===== design/cqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular queue package
// Field widths, opcodes and status codes of the circular queue.
// ----------------------------------------------------------------------------
package cqd_pkg;

    localparam int WORD_W    = 32;
    localparam int OPCODE_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [OPCODE_W-1:0]      opcode_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [FILL_W-1:0]        fill_t;

    // Operation selectors carried on the input tuser.
    localparam opcode_t OP_ENQ  = 2'd0;
    localparam opcode_t OP_DEQ  = 2'd1;
    localparam opcode_t OP_DISP = 2'd2;

    // Result status codes carried on the output tuser.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_OVER  = 2'd1;
    localparam status_t ST_UNDER = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

endpackage

// ===== design/circular_queue_with_dump.sv =====
// An enqueue or any error result is valid in the cycle after acceptance;
// a dequeue or the first displayed word passes through S_READ and the ring
// read register before S_OUT, and so does each further displayed word after
// the previous one is taken. A new word is accepted in the cycle after the
// final result is taken, so an output stall also holds off the next item.
// Reset clears the pointers, count and sequencer; the ring contents are kept.
// ----------------------------------------------------------------------------
// Circular queue with dump
// Ring-buffer queue of DEPTH signed words with enqueue, dequeue and a listing
// of all stored words, driven by a small sequencer over one ring read port.
// ----------------------------------------------------------------------------
`include "circular_queue_with_dump_macros.svh"

module circular_queue_with_dump #(
    parameter int DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cqd_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  logic [cqd_pkg::OPCODE_W-1:0]   s_tuser,   // [1:0] opcode
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cqd_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] word, [35:32] fill_level
    output logic [cqd_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic                           m_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    // Ring storage and its registered read port.
    cqd_pkg::word_t ring [DEPTH];
    cqd_pkg::word_t rd_data_reg;

    state_t         state_reg, state_next;
    ptr_t           head_reg, head_next;
    ptr_t           tail_reg, tail_next;
    ptr_t           scan_reg, scan_next;
    cnt_t           count_reg, count_next;
    cnt_t           remain_reg, remain_next;
    logic           disp_reg, disp_next;
    cqd_pkg::status_t out_status_reg, out_status_next;
    cqd_pkg::word_t   out_word_reg, out_word_next;
    logic             out_last_reg, out_last_next;
    cqd_pkg::fill_t   out_fill_reg, out_fill_next;

    logic           mem_we;
    logic           mem_re;
    ptr_t           mem_raddr;
    logic           s_fire;
    logic           empty;
    logic           full;

    // Advance a ring pointer with wrap from the last entry to the first.
    function automatic ptr_t wrap_next(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    // Reported fill level keeps only the low bits of the count.
    function automatic cqd_pkg::fill_t fill_of(input cnt_t c);
        logic [CNT_W+cqd_pkg::FILL_W-1:0] ext;
        ext = {{cqd_pkg::FILL_W{1'b0}}, c};
        return ext[cqd_pkg::FILL_W-1:0];
    endfunction

    assign s_fire = s_tvalid && s_tready;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));

    // Sequencer next-state and result register loading.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        disp_next       = disp_reg;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        out_fill_next   = out_fill_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    disp_next     = 1'b0;
                    out_last_next = 1'b1;
                    out_word_next = '0;
                    out_fill_next = fill_of(count_reg);
                    case (s_tuser)
                        cqd_pkg::OP_ENQ:
                        begin
                            if (full)
                            begin
                                out_status_next = cqd_pkg::ST_OVER;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                tail_next       = wrap_next(tail_reg);
                                count_next      = cnt_t'(count_reg + 1'b1);
                                out_status_next = cqd_pkg::ST_OK;
                                out_word_next   = s_tdata;
                                out_fill_next   = fill_of(cnt_t'(count_reg + 1'b1));
                            end
                            state_next = S_OUT;
                        end
                        cqd_pkg::OP_DEQ:
                        begin
                            if (empty)
                            begin
                                out_status_next = cqd_pkg::ST_UNDER;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                head_next     = wrap_next(head_reg);
                                count_next    = cnt_t'(count_reg - 1'b1);
                                out_fill_next = fill_of(cnt_t'(count_reg - 1'b1));
                                state_next    = S_READ;
                            end
                        end
                        cqd_pkg::OP_DISP:
                        begin
                            if (empty)
                            begin
                                out_status_next = cqd_pkg::ST_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                scan_next   = wrap_next(head_reg);
                                remain_next = count_reg;
                                disp_next   = 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            // An unused opcode is dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_status_next = cqd_pkg::ST_OK;
                out_word_next   = rd_data_reg;
                out_last_next   = !disp_reg || (remain_reg == cnt_t'(1));
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (disp_reg && (remain_reg != cnt_t'(1)))
                    begin
                        // Fetch the next word of the listing.
                        mem_re      = 1'b1;
                        mem_raddr   = scan_reg;
                        scan_next   = wrap_next(scan_reg);
                        remain_next = cnt_t'(remain_reg - 1'b1);
                        state_next  = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, pointers and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            scan_reg       <= '0;
            count_reg      <= '0;
            remain_reg     <= '0;
            disp_reg       <= 1'b0;
            out_status_reg <= cqd_pkg::ST_OK;
            out_last_reg   <= 1'b0;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            scan_reg       <= scan_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            disp_reg       <= disp_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    // The result word is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // Ring storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring[tail_reg] <= s_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring[mem_raddr];
        end
    end

    // Port drive.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(cqd_pkg::M_TDATA_W - cqd_pkg::WORD_W - cqd_pkg::FILL_W){1'b0}},
                       out_fill_reg, out_word_reg};

    // Assertions.
    `CQD_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "count exceeds depth")
    `CQD_ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid), "input taken while a result waits")
    `CQD_ASSERT_ALWAYS(a_err_word_zero,
        !m_tvalid || (m_tuser == cqd_pkg::ST_OK) || ((out_word_reg == '0) && m_tlast),
        "error result carries a word or is not last")
    `CQD_ASSERT_NEXT(a_enq_count,
        s_fire && (s_tuser == cqd_pkg::OP_ENQ) && !full,
        count_reg == cnt_t'($past(count_reg) + 1'b1), "enqueue did not raise the count")
    `CQD_ASSERT_NEXT(a_deq_count,
        s_fire && (s_tuser == cqd_pkg::OP_DEQ) && !empty,
        count_reg == cnt_t'($past(count_reg) - 1'b1), "dequeue did not lower the count")

endmodule
